### rtl/core/fss_pkg.sv
// ----------------------------------------------------------------------------
// fss_pkg
// Shared constants, codes and types of the free slot stack allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package fss_pkg;

  // pool geometry (slot size is a power of two)
  localparam int unsigned POOL_SLOTS = 4096;
  localparam int unsigned SLOT_BYTES = 4096;
  localparam int unsigned SLOT_SHIFT = $clog2(SLOT_BYTES);

  // field widths
  localparam int unsigned ADDR_W = 64;
  localparam int unsigned IDX_W  = 12;
  localparam int unsigned REQ_W  = 2;
  localparam int unsigned STAT_W = 3;

  // stack pointer and fill count widths
  localparam int unsigned PTR_W = $clog2(POOL_SLOTS);
  localparam int unsigned CNT_W = $clog2(POOL_SLOTS + 1);

  // stream data widths, padded to whole bytes
  localparam int unsigned IN_BITS  = REQ_W + IDX_W + ADDR_W;
  localparam int unsigned OUT_BITS = STAT_W + IDX_W + ADDR_W;
  localparam int unsigned IN_W     = ((IN_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  // request decode: bit 1 set means validate, otherwise bit 0 picks free
  localparam int unsigned REQ_VALIDATE_BIT = 1;
  localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd0;
  localparam logic [REQ_W-1:0] REQ_FREE  = 2'd1;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK         = 3'd0;
  localparam logic [STAT_W-1:0] ST_FULL       = 3'd1;
  localparam logic [STAT_W-1:0] ST_NONE       = 3'd2;
  localparam logic [STAT_W-1:0] ST_BELOW      = 3'd3;
  localparam logic [STAT_W-1:0] ST_MISALIGNED = 3'd4;
  localparam logic [STAT_W-1:0] ST_ABOVE      = 3'd5;

  // stack operation request
  typedef struct packed {
    logic             push;
    logic             pop;
    logic [IDX_W-1:0] push_idx;
  } stack_req_t;

  // stack occupancy flags
  typedef struct packed {
    logic empty;
    logic full;
  } stack_stat_t;

endpackage

`default_nettype wire

### rtl/core/fss_ram.sv
// ----------------------------------------------------------------------------
// fss_ram
// Generic single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module fss_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     en_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write or registered read
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/core/fss_stack.sv
// ----------------------------------------------------------------------------
// fss_stack
// LIFO free list of slot indices held in one RAM, with fill count and a
// low-water mark that stands in for the reset contents (position p holds p).
// ----------------------------------------------------------------------------
`default_nettype none

module fss_stack (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire fss_pkg::stack_req_t      req_i,
  output fss_pkg::stack_stat_t          stat_o,
  output logic [fss_pkg::IDX_W-1:0]     pop_idx_o
);

  logic [fss_pkg::CNT_W-1:0] count_q, count_d;
  logic [fss_pkg::CNT_W-1:0] lmin_q, lmin_d;
  logic [fss_pkg::CNT_W-1:0] top_pos;
  logic                      fill_q;
  logic [fss_pkg::PTR_W-1:0] pos_q;
  logic [fss_pkg::PTR_W-1:0] ram_addr;
  logic [fss_pkg::IDX_W-1:0] ram_rdata;

  assign top_pos = count_q - fss_pkg::CNT_W'(1);

  // occupancy
  assign stat_o.empty = (count_q == '0);
  assign stat_o.full  = (count_q == fss_pkg::CNT_W'(fss_pkg::POOL_SLOTS));

  // push writes at the fill count, pop reads just below it
  assign ram_addr = req_i.push ? count_q[fss_pkg::PTR_W-1:0]
                               : top_pos[fss_pkg::PTR_W-1:0];

  fss_ram #(
    .WIDTH (fss_pkg::IDX_W),
    .DEPTH (fss_pkg::POOL_SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .en_i    (req_i.push | req_i.pop),
    .we_i    (req_i.push),
    .addr_i  (ram_addr),
    .wdata_i (req_i.push_idx),
    .rdata_o (ram_rdata)
  );

  // fill count and low-water mark; every position between the mark and the
  // fill count has been written since reset, those below still hold p
  always_comb begin
    count_d = count_q;
    lmin_d  = lmin_q;
    if (req_i.push) begin
      count_d = count_q + fss_pkg::CNT_W'(1);
    end else if (req_i.pop) begin
      count_d = top_pos;
      if (top_pos < lmin_q) begin
        lmin_d = top_pos;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= fss_pkg::CNT_W'(fss_pkg::POOL_SLOTS);
      lmin_q  <= fss_pkg::CNT_W'(fss_pkg::POOL_SLOTS);
      fill_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      lmin_q  <= lmin_d;
      if (req_i.pop) begin
        fill_q <= (top_pos < lmin_q);
      end
    end
  end

  // position of the popped entry, used as its reset contents
  always_ff @(posedge clk_i) begin
    if (req_i.pop) begin
      pos_q <= top_pos[fss_pkg::PTR_W-1:0];
    end
  end

  assign pop_idx_o = fill_q ? fss_pkg::IDX_W'(pos_q) : ram_rdata;

endmodule

`default_nettype wire

### rtl/core/fss_addr.sv
// ----------------------------------------------------------------------------
// fss_addr
// Slot address arithmetic: address of an allocated slot and range and
// alignment checks of an address against the pool.
// ----------------------------------------------------------------------------
`default_nettype none

module fss_addr (
  input  wire logic [fss_pkg::ADDR_W-1:0] pool_base_i,
  input  wire logic [fss_pkg::IDX_W-1:0]  alloc_idx_i,
  input  wire logic [fss_pkg::ADDR_W-1:0] check_addr_i,
  output logic      [fss_pkg::ADDR_W-1:0] alloc_addr_o,
  output logic      [fss_pkg::STAT_W-1:0] chk_status_o,
  output logic      [fss_pkg::IDX_W-1:0]  chk_idx_o
);

  localparam int unsigned HI_LSB = fss_pkg::SLOT_SHIFT + fss_pkg::PTR_W;

  logic [fss_pkg::ADDR_W:0]   diff;
  logic [fss_pkg::ADDR_W-1:0] offset;
  logic                       below;
  logic                       misaligned;
  logic                       above;

  // base plus index times slot size
  assign alloc_addr_o = pool_base_i +
                        (fss_pkg::ADDR_W'(alloc_idx_i) << fss_pkg::SLOT_SHIFT);

  // offset from the base, borrow marks an address below the pool
  assign diff       = {1'b0, check_addr_i} - {1'b0, pool_base_i};
  assign offset     = diff[fss_pkg::ADDR_W-1:0];
  assign below      = diff[fss_pkg::ADDR_W];
  assign misaligned = |offset[fss_pkg::SLOT_SHIFT-1:0];
  assign above      = |offset[fss_pkg::ADDR_W-1:HI_LSB];

  // checks in priority order
  always_comb begin
    chk_status_o = fss_pkg::ST_OK;
    chk_idx_o    = fss_pkg::IDX_W'(offset[HI_LSB-1:fss_pkg::SLOT_SHIFT]);
    if (below) begin
      chk_status_o = fss_pkg::ST_BELOW;
    end else if (misaligned) begin
      chk_status_o = fss_pkg::ST_MISALIGNED;
    end else if (above) begin
      chk_status_o = fss_pkg::ST_ABOVE;
    end
  end

endmodule

`default_nettype wire

### rtl/core/free_slot_stack_allocator.sv
// ----------------------------------------------------------------------------
// free_slot_stack_allocator
// Fixed-size slot allocator with a LIFO free list of slot indices.
// ----------------------------------------------------------------------------
// Each input beat is a request: allocate pops the top free index and returns
// it with its address (pool_base + index * slot size), free pushes an index,
// validate checks an address for being below, misaligned to or past the end
// of the pool. Every request gives exactly one result beat. Free, validate
// and an allocate on an empty list load the result register directly; an
// allocate that pops reads the free list RAM, whose read data is registered,
// and forms the address from the read data in the wait state ST_POP, while
// the request side is held off. The list holds its reset contents (position
// p holds index p) once reset is released, with no clearing pass. A result
// register parts the two streams, so a new request is taken while a result
// is being drained. The user must write pool_base with cfg_wr_en_i only
// while no request is in flight; the block itself does not enforce it.
`default_nettype none

module free_slot_stack_allocator (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // configuration: pool_base
  input  wire logic                         cfg_wr_en_i,
  input  wire logic [fss_pkg::ADDR_W-1:0]   cfg_wr_data_i,
  // request stream
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  // tdata: req_type[1:0], free_index[13:2], check_addr[77:14], zero pad
  input  wire logic [fss_pkg::IN_W-1:0]     s_axis_tdata,
  // result stream
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  // tdata: status[2:0], granted_index[14:3], result_addr[78:15], zero pad
  output logic      [fss_pkg::OUT_W-1:0]    m_axis_tdata
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_POP  = 1'b1;

  localparam int unsigned FI_LSB = fss_pkg::REQ_W;
  localparam int unsigned CA_LSB = fss_pkg::REQ_W + fss_pkg::IDX_W;

  logic                       state_q, state_d;
  logic [fss_pkg::ADDR_W-1:0] pool_base_q;

  logic [fss_pkg::REQ_W-1:0]  req_type;
  logic [fss_pkg::IDX_W-1:0]  free_index;
  logic [fss_pkg::ADDR_W-1:0] check_addr;
  logic                       in_acc;
  logic                       out_acc;

  fss_pkg::stack_req_t        stk_req;
  fss_pkg::stack_stat_t       stk_stat;
  logic [fss_pkg::IDX_W-1:0]  pop_idx;

  logic [fss_pkg::ADDR_W-1:0] alloc_addr;
  logic [fss_pkg::STAT_W-1:0] chk_status;
  logic [fss_pkg::IDX_W-1:0]  chk_idx;

  logic                       out_vld_q, out_vld_d;
  logic                       out_load;
  logic [fss_pkg::STAT_W-1:0] out_status_q, out_status_d;
  logic [fss_pkg::IDX_W-1:0]  out_idx_q, out_idx_d;
  logic [fss_pkg::ADDR_W-1:0] out_addr_q, out_addr_d;

  // request beat fields
  assign req_type   = s_axis_tdata[fss_pkg::REQ_W-1:0];
  assign free_index = s_axis_tdata[CA_LSB-1:FI_LSB];
  assign check_addr = s_axis_tdata[CA_LSB+fss_pkg::ADDR_W-1:CA_LSB];

  assign s_axis_tready = (state_q == ST_IDLE) && (!out_vld_q || m_axis_tready);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_acc       = out_vld_q && m_axis_tready;

  // pool base register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_base_q <= '0;
    end else if (cfg_wr_en_i) begin
      pool_base_q <= cfg_wr_data_i;
    end
  end

  fss_stack u_stack (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (stk_req),
    .stat_o    (stk_stat),
    .pop_idx_o (pop_idx)
  );

  fss_addr u_addr (
    .pool_base_i  (pool_base_q),
    .alloc_idx_i  (pop_idx),
    .check_addr_i (check_addr),
    .alloc_addr_o (alloc_addr),
    .chk_status_o (chk_status),
    .chk_idx_o    (chk_idx)
  );

  // request decode and sequencing
  always_comb begin
    state_d          = state_q;
    stk_req.push     = 1'b0;
    stk_req.pop      = 1'b0;
    stk_req.push_idx = free_index;
    out_load         = 1'b0;
    out_status_d     = fss_pkg::ST_OK;
    out_idx_d        = '0;
    out_addr_d       = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (req_type[fss_pkg::REQ_VALIDATE_BIT]) begin
            out_load     = 1'b1;
            out_status_d = chk_status;
            if (chk_status == fss_pkg::ST_OK) begin
              out_idx_d  = chk_idx;
              out_addr_d = check_addr;
            end
          end else if (req_type == fss_pkg::REQ_FREE) begin
            out_load = 1'b1;
            if (stk_stat.full) begin
              out_status_d = fss_pkg::ST_FULL;
            end else begin
              stk_req.push = 1'b1;
            end
          end else if (stk_stat.empty) begin
            out_load     = 1'b1;
            out_status_d = fss_pkg::ST_NONE;
          end else begin
            stk_req.pop = 1'b1;
            state_d     = ST_POP;
          end
        end
      end
      ST_POP: begin
        out_load     = 1'b1;
        out_status_d = fss_pkg::ST_OK;
        out_idx_d    = pop_idx;
        out_addr_d   = alloc_addr;
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // result register valid
  always_comb begin
    out_vld_d = out_vld_q;
    if (out_acc) begin
      out_vld_d = 1'b0;
    end
    if (out_load) begin
      out_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q <= out_status_d;
      out_idx_q    <= out_idx_d;
      out_addr_q   <= out_addr_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = fss_pkg::OUT_W'({out_addr_q, out_idx_q, out_status_q});

  // the result register is free whenever the popped entry arrives
  a_pop_slot_free : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_POP) |-> !out_vld_q
  ) else $error("result register still occupied when pop data arrives");

  // an allocate on a non-empty list waits for the read data
  a_pop_enters_wait : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !req_type[fss_pkg::REQ_VALIDATE_BIT] &&
     (req_type == fss_pkg::REQ_ALLOC) && !stk_stat.empty) |=> (state_q == ST_POP)
  ) else $error("allocate did not wait for the free list read");

  // a completed pop always delivers a successful grant
  a_pop_result_ok : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_POP) |=> (out_vld_q && (out_status_q == fss_pkg::ST_OK) &&
                             (state_q == ST_IDLE))
  ) else $error("pop did not produce a grant");

endmodule

`default_nettype wire

### test/fss_grant_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fss_grant_checker
// Watches the request and result streams of the slot allocator, predicts the
// grant for every accepted request beat and compares it with the result beat.
// ----------------------------------------------------------------------------

module fss_grant_checker
  import fss_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_wr_en_i,
  input  logic [ADDR_W-1:0]   cfg_wr_data_i,
  input  logic                req_tvalid_i,
  input  logic                req_tready_i,
  // req_type, free_index, check_addr, zero pad
  input  logic [IN_W-1:0]     req_tdata_i,
  input  logic                res_tvalid_i,
  input  logic                res_tready_i,
  // status, granted_index, result_addr, zero pad
  input  logic [OUT_W-1:0]    res_tdata_i,
  output int unsigned         err_count_o,
  output int unsigned         pending_o
);

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [IDX_W-1:0]  index;
    logic [ADDR_W-1:0] addr;
  } grant_t;

  // shadow of the free list, fill count and pool base
  logic [IDX_W-1:0]  slot_stack [POOL_SLOTS];
  logic [CNT_W-1:0]  slots_free;
  logic [ADDR_W-1:0] pool_base;
  grant_t            grant_queue [$];
  int unsigned       err_count = 0;

  assign err_count_o = err_count;

  task automatic report_mismatch(input string what, input logic [ADDR_W-1:0] got,
                                 input logic [ADDR_W-1:0] want);
    // keep the log short when things go badly wrong
    if (err_count < 50) begin
      $display("%0t: %s: got %h, want %h", $time, what, got, want);
    end
    err_count++;
  endtask

  // grant for one request, updating the shadow list on the way
  function automatic grant_t predict_grant(input logic [REQ_W-1:0] req,
                                           input logic [IDX_W-1:0] fidx,
                                           input logic [ADDR_W-1:0] addr);
    grant_t            g;
    logic [ADDR_W-1:0] offset;
    g = '0;
    if (req[REQ_VALIDATE_BIT]) begin
      // below, then misaligned, then past the end
      if (addr < pool_base) begin
        g.status = ST_BELOW;
      end else begin
        offset = addr - pool_base;
        if (offset[SLOT_SHIFT-1:0] != '0) begin
          g.status = ST_MISALIGNED;
        end else if ((offset >> SLOT_SHIFT) < POOL_SLOTS) begin
          g.status = ST_OK;
          g.index  = offset[SLOT_SHIFT +: IDX_W];
          g.addr   = addr;
        end else begin
          g.status = ST_ABOVE;
        end
      end
    end else if (req == REQ_FREE) begin
      if (slots_free >= POOL_SLOTS) begin
        g.status = ST_FULL;
      end else begin
        slot_stack[slots_free[PTR_W-1:0]] = fidx;
        slots_free++;
        g.status = ST_OK;
      end
    end else begin
      if (slots_free == 0) begin
        g.status = ST_NONE;
      end else begin
        slots_free--;
        g.status = ST_OK;
        g.index  = slot_stack[slots_free[PTR_W-1:0]];
        g.addr   = pool_base + (ADDR_W'(g.index) << SLOT_SHIFT);
      end
    end
    return g;
  endfunction

  // track config, requests and results beat by beat
  always @(posedge clk_i or negedge rst_ni) begin : track
    grant_t want;
    grant_t got;
    if (!rst_ni) begin
      for (int p = 0; p < POOL_SLOTS; p++) slot_stack[p] = IDX_W'(p);
      slots_free = CNT_W'(POOL_SLOTS);
      pool_base  = '0;
      grant_queue.delete();
      pending_o <= 0;
    end else begin
      // results first: a result never belongs to a request of the same edge
      if (res_tvalid_i && res_tready_i) begin
        got.status = res_tdata_i[STAT_W-1:0];
        got.index  = res_tdata_i[STAT_W +: IDX_W];
        got.addr   = res_tdata_i[STAT_W+IDX_W +: ADDR_W];
        if (grant_queue.size() == 0) begin
          report_mismatch("result beat with nothing outstanding", got.addr, '0);
        end else begin
          want = grant_queue.pop_front();
          if (got.status != want.status)
            report_mismatch("status", ADDR_W'(got.status), ADDR_W'(want.status));
          if (got.index != want.index)
            report_mismatch("granted_index", ADDR_W'(got.index), ADDR_W'(want.index));
          if (got.addr != want.addr)
            report_mismatch("result_addr", got.addr, want.addr);
        end
      end
      if (cfg_wr_en_i) begin
        pool_base = cfg_wr_data_i;
      end
      if (req_tvalid_i && req_tready_i) begin
        grant_queue.push_back(predict_grant(req_tdata_i[REQ_W-1:0],
                                            req_tdata_i[REQ_W +: IDX_W],
                                            req_tdata_i[REQ_W+IDX_W +: ADDR_W]));
      end
      pending_o <= grant_queue.size();
    end
  end

endmodule

### test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the free slot stack allocator: directed corner requests, then
// random request mixes over several pool bases, with a heavy allocation phase.
// ----------------------------------------------------------------------------

module testbench;
  import fss_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 500000;
  localparam int unsigned CHOKE_CYCLES = 120;
  localparam int unsigned PHASE_ITEMS  = 280;
  localparam int unsigned TAIL_CYCLES  = 10;

  // validate request codes (only bit 1 is decoded)
  localparam logic [REQ_W-1:0] REQ_CHECK     = 2'd2;
  localparam logic [REQ_W-1:0] REQ_CHECK_ALT = 2'd3;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              cfg_wr_en   = 1'b0;
  logic [ADDR_W-1:0] cfg_wr_data = '0;
  logic              req_tvalid  = 1'b0;
  logic [IN_W-1:0]   req_tdata   = '0;
  logic              res_tready  = 1'b0;
  logic              req_tready;
  logic              res_tvalid;
  logic [OUT_W-1:0]  res_tdata;

  int unsigned       err_count;
  int unsigned       pending;
  int unsigned       cycle_count = 0;
  logic [ADDR_W-1:0] base_now    = '0;
  bit                stalls_on   = 1'b1;
  bit                choke_req   = 1'b0;

  free_slot_stack_allocator i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en),
    .cfg_wr_data_i (cfg_wr_data),
    .s_axis_tvalid (req_tvalid),
    .s_axis_tready (req_tready),
    .s_axis_tdata  (req_tdata),
    .m_axis_tvalid (res_tvalid),
    .m_axis_tready (res_tready),
    .m_axis_tdata  (res_tdata)
  );

  fss_grant_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en),
    .cfg_wr_data_i (cfg_wr_data),
    .req_tvalid_i  (req_tvalid),
    .req_tready_i  (req_tready),
    .req_tdata_i   (req_tdata),
    .res_tvalid_i  (res_tvalid),
    .res_tready_i  (res_tready),
    .res_tdata_i   (res_tdata),
    .err_count_o   (err_count),
    .pending_o     (pending)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  // result side: random back-pressure, plus a long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (choke_req) begin
        choke_req = 1'b0;
        res_tready <= 1'b0;
        repeat (CHOKE_CYCLES) @(posedge clk_i);
      end
      res_tready <= !stalls_on || ($urandom_range(99) >= 12);
    end
  end

  // offer one request beat and wait until it is taken
  task automatic push_req(input logic [REQ_W-1:0] req, input logic [IDX_W-1:0] fidx,
                          input logic [ADDR_W-1:0] addr);
    if (stalls_on && $urandom_range(99) < 12) begin
      req_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    req_tvalid <= 1'b1;
    req_tdata  <= IN_W'({addr, fidx, req});
    do @(posedge clk_i); while (!req_tready);
  endtask

  // pool base is written only once every result has been drained
  task automatic set_pool_base(input logic [ADDR_W-1:0] value);
    req_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    base_now     = value;
    @(posedge clk_i);
    cfg_wr_en <= 1'b0;
  endtask

  // one random request, validate addresses aimed around the pool
  task automatic push_random(input int unsigned alloc_pct, input int unsigned free_pct);
    int unsigned       roll;
    logic [REQ_W-1:0]  req;
    logic [IDX_W-1:0]  fidx;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] slot_addr;
    roll      = $urandom_range(99);
    fidx      = IDX_W'($urandom);
    addr      = {$urandom, $urandom};
    slot_addr = base_now + (ADDR_W'($urandom_range(POOL_SLOTS - 1)) << SLOT_SHIFT);
    if (roll < alloc_pct) begin
      req = REQ_ALLOC;
    end else if (roll < alloc_pct + free_pct) begin
      req = REQ_FREE;
    end else begin
      req = ($urandom_range(3) == 0) ? REQ_CHECK_ALT : REQ_CHECK;
      case ($urandom_range(9))
        0, 1, 2, 3: addr = slot_addr;
        4: begin
          case ($urandom_range(2))
            0:       addr = base_now;
            1:       addr = base_now + (ADDR_W'(POOL_SLOTS - 1) << SLOT_SHIFT);
            default: addr = base_now + (ADDR_W'(POOL_SLOTS) << SLOT_SHIFT);
          endcase
        end
        5, 6: addr = slot_addr + ADDR_W'($urandom_range(1, SLOT_BYTES - 1));
        7: addr = base_now + (ADDR_W'(POOL_SLOTS + $urandom_range(1000)) << SLOT_SHIFT);
        8: addr = base_now - ADDR_W'($urandom_range(1, 1 << 20));
        default: ;
      endcase
    end
    push_req(req, fidx, addr);
  endtask

  // stimulus and verdict
  initial begin
    logic [ADDR_W-1:0] rnd_base;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    set_pool_base('0);

    // full list, top of stack reuse, validate corners with a zero base
    push_req(REQ_FREE, '1, '0);
    push_req(REQ_ALLOC, '0, '1);
    push_req(REQ_FREE, '1, '0);
    push_req(REQ_FREE, '0, '0);
    push_req(REQ_ALLOC, '0, '0);
    push_req(REQ_ALLOC, '0, '0);
    push_req(REQ_CHECK, '0, '0);
    push_req(REQ_CHECK, '0, ADDR_W'(POOL_SLOTS - 1) << SLOT_SHIFT);
    push_req(REQ_CHECK, '0, ADDR_W'(POOL_SLOTS) << SLOT_SHIFT);
    push_req(REQ_CHECK, '0, 64'd1);
    push_req(REQ_CHECK_ALT, '0, '1);
    push_req(REQ_CHECK, '0, 64'hFFFF_FFFF_FFFF_F000);

    // base near the top of the address space: wrapping slot addresses
    set_pool_base(64'hFFFF_FFFF_FFFF_F000);
    push_req(REQ_CHECK, '0, '0);
    push_req(REQ_CHECK, '0, 64'hFFFF_FFFF_FFFF_F000);
    push_req(REQ_CHECK, '0, '1);
    push_req(REQ_ALLOC, '0, '0);

    // all-ones base
    set_pool_base('1);
    push_req(REQ_CHECK, '0, '1);
    push_req(REQ_CHECK, '0, 64'hFFFF_FFFF_FFFF_FFFE);
    push_req(REQ_CHECK_ALT, '0, 64'h0000_0000_0000_0FFF);

    // random mixes, one pool base per phase
    for (int phase = 0; phase < 6; phase++) begin
      rnd_base = {$urandom, $urandom};
      case (phase)
        0: begin
          rnd_base[SLOT_SHIFT-1:0] = '0;
          set_pool_base(rnd_base);
          repeat (PHASE_ITEMS) push_random(35, 35);
        end
        1: begin
          // long stretch with no idling on either side
          set_pool_base('0);
          stalls_on = 1'b0;
          repeat (PHASE_ITEMS) push_random(40, 30);
          stalls_on = 1'b1;
        end
        2: begin
          // receiver holds off while requests keep coming
          set_pool_base(rnd_base);
          choke_req = 1'b1;
          repeat (PHASE_ITEMS) push_random(30, 30);
        end
        3: begin
          // mostly allocations, walking deep down the list
          set_pool_base('1);
          repeat (PHASE_ITEMS) push_random(92, 2);
          repeat (12) push_random(70, 10);
        end
        4: begin
          set_pool_base(64'hFFFF_FFFF_FFFF_F000);
          repeat (PHASE_ITEMS) push_random(30, 45);
        end
        default: begin
          set_pool_base(rnd_base);
          choke_req = 1'b1;
          repeat (PHASE_ITEMS) push_random(35, 35);
        end
      endcase
    end

    // let every result drain, then a short tail
    req_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (err_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/fss_pkg.sv
rtl/core/fss_ram.sv
rtl/core/fss_stack.sv
rtl/core/fss_addr.sv
rtl/core/free_slot_stack_allocator.sv
test/fss_grant_checker.sv
test/testbench.sv
